>>> hw/rtl/sads_pkg.sv
// Shared definitions for the two-stacks-in-one-store block.
// Field widths, operation and selector codes, result status codes.
// No dependencies.
`default_nettype none

package sads_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // op field
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // stack_sel field
  localparam logic SEL_LOW  = 1'b0;
  localparam logic SEL_HIGH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

`default_nettype wire

>>> hw/rtl/sads_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on sads_pkg.
`default_nettype none

interface sads_req_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic              stack_sel;
  sads_pkg::word_t   push_value;

  modport source (output valid, output op, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input op, input stack_sel, input push_value,
                  output ready);
endinterface

interface sads_rsp_if;
  logic                valid;
  logic                ready;
  sads_pkg::status_e   status;
  sads_pkg::word_t     pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/shared_array_dual_stack.sv
// Two stacks sharing one store: low stack grows up from slot 0, high stack
// grows down from slot DEPTH-1. Depends on sads_pkg, sads_if, sads_ram.
//
// Usage:
//   req_i carries one operation per transfer: op (push/pop), stack_sel
//   (low/high) and push_value. rsp_o returns exactly one result per request:
//   status (ok, full, empty) and pop_value (popped word, zero otherwise).
//   A request's result shows in the cycle after it is taken, the popped word
//   coming straight from the store's read register.
//   Throughput is one request per cycle while rsp_o is taken every cycle;
//   each operation not refused makes a single access to the one store port.
//   A push is refused (full) when both stacks together hold DEPTH words; a
//   pop on an empty stack is refused (empty). Refused operations change
//   nothing.
//   When the receiver stalls, the pending result holds and req_i.ready drops
//   until the result transfers.
//   Reset empties both stacks at once; store contents are not cleared, and
//   only words pushed after reset can be popped.
`default_nettype none

module shared_array_dual_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sads_req_if.sink  req_i,
  sads_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_XC = (CW+1)'(DEPTH);

  // word counts of each stack
  logic [CW-1:0] low_cnt_q, low_cnt_d;
  logic [CW-1:0] high_cnt_q, high_cnt_d;

  logic               s1_valid_q, s1_valid_d;
  sads_pkg::status_e  s1_status_q, status_d;
  logic               s1_pop_q, pop_ok_d;

  logic          accept;
  logic          full;
  logic [CW-1:0] lo_pop_addr, hi_push_addr, hi_pop_addr;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [sads_pkg::WORD_W-1:0] ram_rdata;

  assign req_i.ready = !s1_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full = ({1'b0, low_cnt_q} + {1'b0, high_cnt_q}) == DEPTH_XC;

  assign lo_pop_addr  = low_cnt_q - CW'(1);
  assign hi_push_addr = DEPTH_C - high_cnt_q - CW'(1);
  assign hi_pop_addr  = DEPTH_C - high_cnt_q;

  always_comb begin
    low_cnt_d  = low_cnt_q;
    high_cnt_d = high_cnt_q;
    status_d   = sads_pkg::ST_OK;
    pop_ok_d   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = low_cnt_q[AW-1:0];
    case (req_i.op)
      sads_pkg::OP_PUSH: begin
        if (full) begin
          status_d = sads_pkg::ST_FULL;
        end else if (req_i.stack_sel == sads_pkg::SEL_LOW) begin
          ram_we    = accept;
          ram_addr  = low_cnt_q[AW-1:0];
          low_cnt_d = low_cnt_q + CW'(1);
        end else begin
          ram_we     = accept;
          ram_addr   = hi_push_addr[AW-1:0];
          high_cnt_d = high_cnt_q + CW'(1);
        end
      end
      default: begin
        if (req_i.stack_sel == sads_pkg::SEL_LOW) begin
          if (low_cnt_q == '0) begin
            status_d = sads_pkg::ST_EMPTY;
          end else begin
            pop_ok_d  = 1'b1;
            ram_re    = accept;
            ram_addr  = lo_pop_addr[AW-1:0];
            low_cnt_d = low_cnt_q - CW'(1);
          end
        end else begin
          if (high_cnt_q == '0) begin
            status_d = sads_pkg::ST_EMPTY;
          end else begin
            pop_ok_d   = 1'b1;
            ram_re     = accept;
            ram_addr   = hi_pop_addr[AW-1:0];
            high_cnt_d = high_cnt_q - CW'(1);
          end
        end
      end
    endcase
  end

  assign s1_valid_d = req_i.ready ? accept : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q  <= '0;
      high_cnt_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        low_cnt_q  <= low_cnt_d;
        high_cnt_q <= high_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_pop_q    <= pop_ok_d;
    end
  end

  sads_ram #(
    .WIDTH (sads_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (req_i.push_value),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid     = s1_valid_q;
  assign rsp_o.status    = s1_status_q;
  assign rsp_o.pop_value = s1_pop_q ? sads_pkg::word_t'(ram_rdata) : '0;

endmodule

`default_nettype wire

>>> hw/rtl/sads_ram.sv
// Generic single-port RAM, one access per cycle, registered read data.
// Read data holds when no read is issued. No dependencies.
`default_nettype none

module sads_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/sads_chk.sv
// Port-level checker for shared_array_dual_stack, attached by bind.
// Depends on sads_pkg and the top level's channel ports.
`default_nettype none

module sads_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire sads_pkg::status_e rsp_status_i,
  input wire sads_pkg::word_t   rsp_pop_value_i
);

  logic req_xfer;
  assign req_xfer = req_valid_i && req_ready_i;

  // refused operations carry no word
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != sads_pkg::ST_OK |-> rsp_pop_value_i == '0)
    else $error("non-success result carries a nonzero word");

  // every request shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> rsp_valid_i)
    else $error("result missing one cycle after request transfer");

  // a fresh result only follows a request transfer
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_xfer))
    else $error("result appeared without a request");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_pop_value_i))
    else $error("stalled result changed");

endmodule

bind shared_array_dual_stack sads_chk u_sads_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_pop_value_i (rsp_o.pop_value)
);

`default_nettype wire
